// ===== hw/rtl/wss_pkg.sv =====
// Package for the wildcard signature search block.
// Holds the input and result beat types and the command and step-kind codes.
// No dependencies.
package wss_pkg;

	localparam int STEP_INDEX_W = 6;
	localparam int OFFSET_W     = 16;
	localparam int CFG_W        = 7;

	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_BYTE = 1'b1;

	localparam logic KIND_EXACT = 1'b0;
	localparam logic KIND_ANY   = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic [STEP_INDEX_W-1:0] step_index;
		logic                    step_kind;
		logic [7:0]              step_value;
		logic [7:0]              data_byte;
		logic                    last;
	} item_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] match_offset;
	} result_t;

	typedef struct packed {
		logic    emit;
		result_t result;
	} core_out_t;

endpackage

// ===== hw/rtl/wss_match_core.sv =====
// Step table and shift-and partial match vector for the signature search.
// Evaluates one registered beat per cycle while fire is high and updates the stream state.
// Depends on wss_pkg.
module wss_match_core
	import wss_pkg::*;
#(
	parameter int MAX_STEPS     = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  item_t            item,
	input  logic [CFG_W-1:0] pattern_length,
	output core_out_t        core_out
);

	localparam int LEN_W = $clog2(MAX_STEPS + 1);
	localparam int IDX_W = $clog2(MAX_STEPS);

	logic                     step_kind_q [MAX_STEPS];
	logic [7:0]               step_value_q [MAX_STEPS];
	logic [MAX_STEPS-1:0]     pm_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     reported_q;

	logic [LEN_W-1:0]         len;
	logic [LEN_W-1:0]         len_m1;
	logic [MAX_STEPS-1:0]     step_ok;
	logic [MAX_STEPS-1:0]     pm_next;
	logic                     done;
	logic                     pos_max;
	logic                     hit;
	logic [POSITION_BITS-1:0] offset;
	logic                     byte_fire;
	logic                     step_fire;

	assign byte_fire = fire && (item.cmd == CMD_BYTE);
	assign step_fire = fire && (item.cmd == CMD_STEP);

	always_ff @(posedge clk) begin
		if (step_fire && (int'(item.step_index) < MAX_STEPS)) begin
			step_kind_q[IDX_W'(item.step_index)]  <= item.step_kind;
			step_value_q[IDX_W'(item.step_index)] <= item.step_value;
		end
	end

	always_comb begin
		if (int'(pattern_length) > MAX_STEPS) begin
			len = LEN_W'(MAX_STEPS);
		end else begin
			len = LEN_W'(pattern_length);
		end
		len_m1 = len - LEN_W'(1);
		for (int i = 0; i < MAX_STEPS; i++) begin
			step_ok[i] = (i < int'(len)) &&
				((step_kind_q[i] == KIND_ANY) || (step_value_q[i] == item.data_byte));
		end
		pm_next = {pm_q[MAX_STEPS-2:0], 1'b1} & step_ok;
		done    = (len == '0) ? 1'b1 : pm_next[len_m1[IDX_W-1:0]];
		pos_max = (pos_q == '1);
		hit     = done && !reported_q && !pos_max;
		offset  = (len == '0) ? '0 : pos_q - POSITION_BITS'(len_m1);

		core_out.emit = 1'b0;
		core_out.result.found = 1'b0;
		core_out.result.match_offset = '0;
		if (byte_fire) begin
			if (hit) begin
				core_out.emit = 1'b1;
				core_out.result.found = 1'b1;
				core_out.result.match_offset = OFFSET_W'(offset);
			end else if (item.last && !reported_q) begin
				core_out.emit = 1'b1;
			end
		end
	end

	// an empty signature leaves the partial matches untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q       <= '0;
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (byte_fire) begin
			if (item.last) begin
				pm_q       <= '0;
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				pm_q       <= (len == '0) ? pm_q : pm_next;
				pos_q      <= pos_max ? pos_q : pos_q + POSITION_BITS'(1);
				reported_q <= reported_q | hit;
			end
		end
	end

	// one report per buffer
	a_no_second_report: assert property (@(posedge clk) disable iff (!arst_n)
		reported_q && byte_fire |-> !core_out.emit)
		else $error("result after match already reported");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		core_out.emit && !core_out.result.found |-> core_out.result.match_offset == '0)
		else $error("not-found result with nonzero offset");

	a_pos_advances: assert property (@(posedge clk) disable iff (!arst_n)
		byte_fire && !item.last |=> pos_q != '0)
		else $error("position did not advance");

endmodule

// ===== hw/rtl/wildcard_signature_search.sv =====
// Wildcard signature search, top level. Depends on wss_pkg and wss_match_core.
// An accepted beat is held in the staging register, then its result is registered in the result register.
// Throughput: one beat per cycle when not stalled; all steps compare in parallel in one stage.
// Input stalls only while the result register holds an untaken result and
// the staged beat is pending. Reset clears control state and the length;
// the step table is undefined until written and gets no clearing pass.
module wildcard_signature_search
	import wss_pkg::*;
#(
	parameter int MAX_STEPS     = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic             valid_s1;
	item_t            item_s1;
	logic [CFG_W-1:0] pattern_length_q;
	logic             result_valid_q;
	result_t          result_q;
	logic             out_hold;
	logic             fire_s1;
	core_out_t        core_out;

	assign cfg_ready    = 1'b1;
	assign out_hold     = result_valid_q && result_stall;
	assign fire_s1      = valid_s1 && !out_hold;
	assign item_stall   = valid_s1 && out_hold;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			pattern_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	wss_match_core #(
		.MAX_STEPS     (MAX_STEPS),
		.POSITION_BITS (POSITION_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire_s1),
		.item           (item_s1),
		.pattern_length (pattern_length_q),
		.core_out       (core_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (!out_hold) begin
			result_valid_q <= core_out.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_hold) begin
			result_q <= core_out.result;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled without a blocked result");

	a_no_emit_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_hold |-> !core_out.emit)
		else $error("core produced a result while output blocked");

	a_beat_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_hold && !(item_valid && !item_stall) |=> !valid_s1)
		else $error("staged beat not retired");

endmodule
